// ===== sv/llmon_pkg.sv =====
// Shared types, codes and constants of the link latency LED monitor.
package llmon_pkg;

    // Number of monitored ports; the result word carries one LED per port.
    localparam int PORTS = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_PWM_PERIOD = 32;
    localparam int DEF_TIMER_BITS = 16;

    // Configuration register geometry.
    localparam int CFG_BITS  = 16;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Blink timing in ticks of the 8 kHz time base.
    localparam logic [CFG_BITS-1:0] BLINK_FIRST_TICKS = 16'd32000;
    localparam logic [CFG_BITS-1:0] BLINK_ON_TICKS    = 16'd2400;

    // Register indexes of the configuration space.
    typedef enum logic [2:0] {
        REG_LATE         = 3'd0,
        REG_STALE        = 3'd1,
        REG_HOT_NORMAL   = 3'd2,
        REG_HOT_DROPPED  = 3'd3,
        REG_LATE_HOLD    = 3'd4,
        REG_STALE_HOLD   = 3'd5,
        REG_DROPPED_HOLD = 3'd6,
        REG_BLINK_PERIOD = 3'd7
    } reg_idx_t;

    // Operation codes of an input word.
    typedef enum logic [3:0] {
        OP_TICK          = 4'd0,
        OP_UNPOWERED     = 4'd1,
        OP_POWERED       = 4'd2,
        OP_OFFLINE       = 4'd3,
        OP_ONLINE        = 4'd4,
        OP_DROP_INCOMING = 4'd5,
        OP_PACKET_START  = 4'd6,
        OP_DELIVERED     = 4'd7,
        OP_PACKET_DROPPED = 4'd8
    } op_t;

    // LED colors as driven on the result word.
    typedef enum logic [2:0] {
        COL_OFF     = 3'd0,
        COL_RED     = 3'd1,
        COL_GREEN   = 3'd2,
        COL_BLUE    = 3'd3,
        COL_YELLOW  = 3'd4,
        COL_CYAN    = 3'd5,
        COL_MAGENTA = 3'd6
    } color_t;

    // Latency class of the most recent packet.
    typedef enum logic [1:0] {
        LAT_REALTIME = 2'd0,
        LAT_LATE     = 2'd1,
        LAT_STALE    = 2'd2,
        LAT_DROPPED  = 2'd3
    } lat_t;

    // Brightness levels: 1/32 duty, 1/8 duty, full duty.
    typedef enum logic [1:0] {
        BR_DIM    = 2'd0,
        BR_NORMAL = 2'd1,
        BR_BRIGHT = 2'd2
    } bright_t;

    // One LED setting as chosen by the display evaluation.
    typedef struct packed {
        color_t  color;
        bright_t bright;
        logic    blink;
    } led_t;

    // Configuration register file.
    typedef struct packed {
        logic [CFG_BITS-1:0] late_ticks;
        logic [CFG_BITS-1:0] stale_ticks;
        logic [CFG_BITS-1:0] hot_normal_ticks;
        logic [CFG_BITS-1:0] hot_dropped_ticks;
        logic [CFG_BITS-1:0] late_hold_ticks;
        logic [CFG_BITS-1:0] stale_hold_ticks;
        logic [CFG_BITS-1:0] dropped_hold_ticks;
        logic [CFG_BITS-1:0] blink_period_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        late_ticks:         16'd9,
        stale_ticks:        16'd80,
        hot_normal_ticks:   16'd160,
        hot_dropped_ticks:  16'd2400,
        late_hold_ticks:    16'd16000,
        stale_hold_ticks:   16'd32000,
        dropped_hold_ticks: 16'd48000,
        blink_period_ticks: 16'd24000
    };

endpackage

// ===== sv/link_latency_led_monitor.sv =====
// Top level of the link latency LED monitor: input register, evaluation and result register.
//
// Usage:
// - The input channel (item_valid, item_stall, operation, port) carries one word per
//   link event or per tick of the 8 kHz time base.
// - A tick returns one result word with both LED write flags set; a packet start
//   returns one result word that writes only that port's LED. Other events update
//   the port state and return nothing.
// - The result channel (result_valid, result_stall, led*_write, led*_color) holds a
//   word in its output register until it is taken.
// - A word passes through the input register and then the result register before its
//   result word can be taken. The evaluation of both ports, the timer aging and the
//   LED drive compare all sit in the single stage between them.
// - Throughput is one word per cycle; a new word enters while the previous result is
//   still waiting. A stalled receiver holds the result register, and the input stage
//   then stalls only if its word would produce a result.
// - The user sets thresholds and hold times through the APB port only while the block
//   is idle; the block itself does not enforce this.
// - Reset clears all port state, loads the register defaults, sets the PWM counter to
//   its period and the blink counter to the default blink period.
module link_latency_led_monitor #(
    parameter int PWM_PERIOD = llmon_pkg::DEF_PWM_PERIOD,
    parameter int TIMER_BITS = llmon_pkg::DEF_TIMER_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Input channel.
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [3:0]                       operation,
    input  logic                             port,

    // Result channel.
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             led0_write,
    output logic [2:0]                       led0_color,
    output logic                             led1_write,
    output logic [2:0]                       led1_color,

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [llmon_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [llmon_pkg::DATA_BITS-1:0]  pwdata,
    output logic [llmon_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready
);

    localparam int PWM_W = $clog2(PWM_PERIOD + 1);
    localparam int CFG_W = llmon_pkg::CFG_BITS;

    typedef logic [PWM_W-1:0] pwm_t;

    // Per-port state.
    typedef struct packed {
        logic                  powered;
        logic                  online;
        logic [TIMER_BITS-1:0] age;
        llmon_pkg::lat_t       lat;
        logic                  drop_pend;
        logic [CFG_W-1:0]      hot;
        logic [CFG_W-1:0]      late_tmr;
        logic [CFG_W-1:0]      stale_tmr;
        logic [CFG_W-1:0]      drop_tmr;
    } port_st_t;

    // Outcome of one display evaluation.
    typedef struct packed {
        port_st_t        st;
        llmon_pkg::led_t led;
    } eval_t;

    // Display evaluation of one port: updates history timers and picks the LED setting.
    function automatic eval_t eval_port(port_st_t s, llmon_pkg::cfg_t c);
        eval_t r;
        r.st  = s;
        r.led = '{color: llmon_pkg::COL_OFF, bright: llmon_pkg::BR_DIM, blink: 1'b0};
        if (!s.online) begin
            r.led.color = s.powered ? llmon_pkg::COL_CYAN : llmon_pkg::COL_BLUE;
            r.led.blink = 1'b1;
        end else if (s.age != '0) begin
            r.st.hot      = c.hot_normal_ticks;
            r.led.bright  = llmon_pkg::BR_BRIGHT;
            if (s.age < TIMER_BITS'(c.late_ticks)) begin
                r.st.lat = llmon_pkg::LAT_REALTIME;
                if (s.drop_tmr != '0)       r.led.color = llmon_pkg::COL_MAGENTA;
                else if (s.stale_tmr != '0) r.led.color = llmon_pkg::COL_RED;
                else if (s.late_tmr != '0)  r.led.color = llmon_pkg::COL_YELLOW;
                else                        r.led.color = llmon_pkg::COL_CYAN;
            end else if (s.age < TIMER_BITS'(c.stale_ticks)) begin
                r.st.lat      = llmon_pkg::LAT_LATE;
                r.st.late_tmr = c.late_hold_ticks;
                r.led.color   = llmon_pkg::COL_YELLOW;
            end else begin
                r.st.lat       = llmon_pkg::LAT_STALE;
                r.st.stale_tmr = c.stale_hold_ticks;
                r.led.color    = llmon_pkg::COL_RED;
            end
        end else begin
            // A pending drop turns into dropped history first.
            if (s.drop_pend) begin
                r.st.drop_pend = 1'b0;
                r.st.hot       = c.hot_dropped_ticks;
                r.st.drop_tmr  = c.dropped_hold_ticks;
                r.st.lat       = llmon_pkg::LAT_DROPPED;
            end
            if (r.st.hot != '0) begin
                r.led.bright = llmon_pkg::BR_NORMAL;
                unique case (r.st.lat)
                    llmon_pkg::LAT_REALTIME: r.led.color = llmon_pkg::COL_GREEN;
                    llmon_pkg::LAT_LATE:     r.led.color = llmon_pkg::COL_YELLOW;
                    llmon_pkg::LAT_STALE:    r.led.color = llmon_pkg::COL_RED;
                    default:
                    begin
                        r.led.color  = llmon_pkg::COL_MAGENTA;
                        r.led.bright = llmon_pkg::BR_BRIGHT;
                    end
                endcase
            end else if (r.st.drop_tmr != '0) begin
                r.led.color  = llmon_pkg::COL_MAGENTA;
                r.led.bright = llmon_pkg::BR_NORMAL;
            end else if (r.st.stale_tmr != '0) begin
                r.led.color = llmon_pkg::COL_RED;
            end else if (r.st.late_tmr != '0) begin
                r.led.color = llmon_pkg::COL_YELLOW;
            end else begin
                r.led.color = llmon_pkg::COL_GREEN;
            end
        end
        return r;
    endfunction

    // Per-tick aging of the packet age and the hold timers.
    function automatic port_st_t age_port(port_st_t s);
        port_st_t r;
        r = s;
        if (s.online && s.age != '0 && s.age != '1) r.age = s.age + 1'b1;
        if (s.hot != '0)       r.hot       = s.hot - 1'b1;
        if (s.late_tmr != '0)  r.late_tmr  = s.late_tmr - 1'b1;
        if (s.stale_tmr != '0) r.stale_tmr = s.stale_tmr - 1'b1;
        if (s.drop_tmr != '0)  r.drop_tmr  = s.drop_tmr - 1'b1;
        return r;
    endfunction

    // Color actually driven this tick, after PWM and blink gating.
    function automatic llmon_pkg::color_t drive_led(llmon_pkg::led_t l, pwm_t pwm,
                                                    logic blink_dark);
        logic on;
        on = 1'b1;
        unique case (l.bright)
            llmon_pkg::BR_DIM:    on = (pwm == PWM_W'(PWM_PERIOD));
            llmon_pkg::BR_NORMAL: on = (pwm[2:0] == 3'd0);
            default:              on = 1'b1;
        endcase
        if (l.blink && blink_dark) on = 1'b0;
        return on ? l.color : llmon_pkg::COL_OFF;
    endfunction

    // Registers.
    llmon_pkg::cfg_t            cfg_reg;
    logic                       in_valid_reg;
    logic [3:0]                 op_reg;
    logic                       port_reg;
    port_st_t                   st_reg  [llmon_pkg::PORTS];
    port_st_t                   st_next [llmon_pkg::PORTS];
    pwm_t                       pwm_reg, pwm_next;
    logic [CFG_W-1:0]           blink_reg, blink_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       write_reg [llmon_pkg::PORTS];
    logic                       write_next [llmon_pkg::PORTS];
    llmon_pkg::color_t          color_reg [llmon_pkg::PORTS];
    llmon_pkg::color_t          color_next [llmon_pkg::PORTS];

    // Working signals.
    logic                       is_tick;
    logic                       is_start;
    logic                       has_result;
    logic                       advance;
    logic                       cfg_write;
    logic [CFG_W-1:0]           off_time;
    logic                       blink_dark;
    port_st_t                   eval_in [llmon_pkg::PORTS];
    eval_t                      eval_res [llmon_pkg::PORTS];

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= llmon_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (llmon_pkg::reg_idx_t'(paddr[4:2]))
                llmon_pkg::REG_LATE:         cfg_reg.late_ticks         <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_STALE:        cfg_reg.stale_ticks        <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_HOT_NORMAL:   cfg_reg.hot_normal_ticks   <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_HOT_DROPPED:  cfg_reg.hot_dropped_ticks  <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_LATE_HOLD:    cfg_reg.late_hold_ticks    <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_STALE_HOLD:   cfg_reg.stale_hold_ticks   <= pwdata[CFG_W-1:0];
                llmon_pkg::REG_DROPPED_HOLD: cfg_reg.dropped_hold_ticks <= pwdata[CFG_W-1:0];
                default:                     cfg_reg.blink_period_ticks <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (llmon_pkg::reg_idx_t'(paddr[4:2]))
            llmon_pkg::REG_LATE:         prdata[CFG_W-1:0] = cfg_reg.late_ticks;
            llmon_pkg::REG_STALE:        prdata[CFG_W-1:0] = cfg_reg.stale_ticks;
            llmon_pkg::REG_HOT_NORMAL:   prdata[CFG_W-1:0] = cfg_reg.hot_normal_ticks;
            llmon_pkg::REG_HOT_DROPPED:  prdata[CFG_W-1:0] = cfg_reg.hot_dropped_ticks;
            llmon_pkg::REG_LATE_HOLD:    prdata[CFG_W-1:0] = cfg_reg.late_hold_ticks;
            llmon_pkg::REG_STALE_HOLD:   prdata[CFG_W-1:0] = cfg_reg.stale_hold_ticks;
            llmon_pkg::REG_DROPPED_HOLD: prdata[CFG_W-1:0] = cfg_reg.dropped_hold_ticks;
            default:                     prdata[CFG_W-1:0] = cfg_reg.blink_period_ticks;
        endcase
    end

    // Handshake: a word leaves the input register when it needs no result slot or
    // when the result register is empty or being emptied.
    assign is_tick    = (op_reg == llmon_pkg::OP_TICK);
    assign is_start   = (op_reg == llmon_pkg::OP_PACKET_START);
    assign has_result = is_tick || is_start;
    assign advance    = in_valid_reg && (!has_result || !out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            op_reg   <= operation;
            port_reg <= port;
        end
    end

    // Blink gating: dark for the off part of the blink cycle.
    assign off_time   = (cfg_reg.blink_period_ticks > llmon_pkg::BLINK_ON_TICKS) ?
                        (cfg_reg.blink_period_ticks - llmon_pkg::BLINK_ON_TICKS) : '0;
    assign blink_dark = (blink_reg < off_time);

    // Evaluate every port; a packet start sees its port's age restarted at one.
    always_comb
    begin
        for (int q = 0; q < llmon_pkg::PORTS; q++)
        begin
            eval_in[q] = st_reg[q];
            if (is_start && port_reg == 1'(q)) eval_in[q].age = TIMER_BITS'(1);
            eval_res[q] = eval_port(eval_in[q], cfg_reg);
        end
    end

    // Next port state and shared counters.
    always_comb
    begin
        pwm_next   = pwm_reg;
        blink_next = blink_reg;
        for (int q = 0; q < llmon_pkg::PORTS; q++)
        begin
            st_next[q] = st_reg[q];
            if (advance)
            begin
                unique case (op_reg)
                    llmon_pkg::OP_TICK:
                        st_next[q] = age_port(eval_res[q].st);
                    llmon_pkg::OP_UNPOWERED,
                    llmon_pkg::OP_POWERED:
                        if (port_reg == 1'(q))
                            st_next[q].powered = (op_reg == llmon_pkg::OP_POWERED);
                    llmon_pkg::OP_OFFLINE:
                        if (port_reg == 1'(q)) st_next[q].online = 1'b0;
                    llmon_pkg::OP_ONLINE:
                        if (port_reg == 1'(q)) st_next[q].online = 1'b1;
                    llmon_pkg::OP_DROP_INCOMING:
                        if (port_reg == 1'(q)) st_next[q].drop_pend = 1'b1;
                    llmon_pkg::OP_PACKET_START:
                        if (port_reg == 1'(q)) st_next[q] = eval_res[q].st;
                    llmon_pkg::OP_DELIVERED:
                        if (port_reg == 1'(q)) st_next[q].age = '0;
                    llmon_pkg::OP_PACKET_DROPPED:
                        if (port_reg == 1'(q))
                        begin
                            st_next[q].drop_pend = 1'b1;
                            st_next[q].age       = '0;
                        end
                    default:
                        st_next[q] = st_reg[q];
                endcase
            end
        end
        if (advance)
        begin
            if (is_tick)
            begin
                pwm_next   = (pwm_reg <= pwm_t'(1)) ? PWM_W'(PWM_PERIOD) : pwm_reg - 1'b1;
                blink_next = (blink_reg <= CFG_W'(1)) ? cfg_reg.blink_period_ticks :
                             blink_reg - 1'b1;
            end
            else if (op_reg == llmon_pkg::OP_UNPOWERED || op_reg == llmon_pkg::OP_POWERED ||
                     op_reg == llmon_pkg::OP_OFFLINE)
            begin
                blink_next = llmon_pkg::BLINK_FIRST_TICKS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < llmon_pkg::PORTS; q++)
            begin
                st_reg[q] <= '{powered: 1'b0, online: 1'b0, age: '0,
                               lat: llmon_pkg::LAT_REALTIME, drop_pend: 1'b0,
                               hot: '0, late_tmr: '0, stale_tmr: '0, drop_tmr: '0};
            end
            pwm_reg   <= PWM_W'(PWM_PERIOD);
            blink_reg <= llmon_pkg::CFG_RESET.blink_period_ticks;
        end
        else
        begin
            for (int q = 0; q < llmon_pkg::PORTS; q++) st_reg[q] <= st_next[q];
            pwm_reg   <= pwm_next;
            blink_reg <= blink_next;
        end
    end

    // Result word: a tick writes every LED, a packet start only its own.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        for (int q = 0; q < llmon_pkg::PORTS; q++)
        begin
            write_next[q] = write_reg[q];
            color_next[q] = color_reg[q];
        end
        if (advance && has_result)
        begin
            out_valid_next = 1'b1;
            for (int q = 0; q < llmon_pkg::PORTS; q++)
            begin
                write_next[q] = is_tick || (port_reg == 1'(q));
                color_next[q] = write_next[q] ?
                                drive_led(eval_res[q].led, pwm_reg, blink_dark) :
                                llmon_pkg::COL_OFF;
            end
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int q = 0; q < llmon_pkg::PORTS; q++)
        begin
            write_reg[q] <= write_next[q];
            color_reg[q] <= color_next[q];
        end
    end

    assign result_valid = out_valid_reg;
    assign led0_write   = write_reg[0];
    assign led0_color   = color_reg[0];
    assign led1_write   = write_reg[1];
    assign led1_color   = color_reg[1];

    // Every result word writes at least one LED.
    a_result_writes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (write_reg[0] || write_reg[1]))
        else $error("result word without any LED write");

    // LED 0, when it is not written, carries the off code.
    a_unwritten_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !write_reg[0] |-> color_reg[0] == llmon_pkg::COL_OFF)
        else $error("unwritten LED 0 carries a color");

    // The PWM counter stays within one period.
    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_reg != '0 && pwm_reg <= PWM_W'(PWM_PERIOD))
        else $error("PWM counter out of range");

    // Every processed tick moves the PWM counter.
    a_tick_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_tick |=> pwm_reg != $past(pwm_reg))
        else $error("tick did not advance the PWM counter");

    // A word held in the input register is not lost while it waits.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(op_reg))
        else $error("waiting input word lost");

endmodule
